@@ sv/ist_pkg.sv @@
// shared types and constants for the integer set table
package ist_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_OUT_W      = 5;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } ist_cmd_e;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] member_count;
        logic                   rejected_full;
        logic                   was_present;
    } ist_result_t;

endpackage

@@ sv/integer_set_table.sv @@
// integer set table: top level with stream ports and result register
//
// Holds a set of distinct 32-bit integers in an unsorted table of CAPACITY
// entries. Each input beat carries a command in s_tuser (0 insert, 1 remove)
// and the value in s_tdata. Each beat gives exactly one result beat on the
// m_ side: was_present, rejected_full and the member count after the item.
// An insert of a value already held changes nothing; an insert of a new value
// into a full table is refused with rejected_full set. A remove moves the
// last live entry into the freed slot.
// The engine handles one item at a time. After accept it scans the live
// entries until a match or the end; a remove that moves an entry then reads
// the last entry and writes it into the freed slot, and the result waits in
// the done state until the output register takes it. The next beat is accepted
// in the cycle after the result leaves the engine. The search walks the entry
// memory through its single read port, one entry per cycle.
// Reset clears the count and control state; entry contents stay as they are
// and are never read before written. While the receiver stalls the result
// stays in the output register; the engine takes the next item meanwhile and
// holds its own result until the register frees.
module integer_set_table
    import ist_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // value[31:0]
    input  logic [0:0]  s_tuser,  // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // was_present[0], rejected_full[1], member_count[6:2], zero[7]
);

    logic        res_valid;
    logic        res_ready;
    ist_result_t res;

    logic        m_tvalid_reg;
    ist_result_t m_res_reg;

    ist_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (ist_cmd_e'(s_tuser[0])),
        .in_value   (s_tdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_res_reg.member_count, m_res_reg.rejected_full,
                       m_res_reg.was_present};

endmodule

@@ sv/ist_core.sv @@
// search, append and move-last engine around the entry memory
module ist_core
    import ist_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  ist_cmd_e                  in_command,
    input  logic signed [VALUE_W-1:0] in_value,
    output logic                      res_valid,
    input  logic                      res_ready,
    output ist_result_t               res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_MOVE_RD = 5'b00100,
        S_MOVE_WR = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    ist_cmd_e                   cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0]  value_reg, value_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              rd_idx_reg, rd_idx_next;
    logic                       pend_reg, pend_next;
    logic [IW-1:0]              pend_idx_reg, pend_idx_next;
    logic [IW-1:0]              slot_reg, slot_next;
    logic                       hit_reg, hit_next;
    logic                       rej_reg, rej_next;

    logic [VALUE_W-1:0]         mem [0:CAPACITY-1];
    logic [VALUE_W-1:0]         rd_data_reg;
    logic [IW-1:0]              mem_raddr;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    logic [VALUE_W-1:0]         mem_wdata;

    logic [CW-1:0]              last_cnt;
    logic [IW-1:0]              last_idx;
    logic                       issue;
    logic                       hit_now;
    logic                       scan_miss;

    assign last_cnt  = count_reg - CW'(1);
    assign last_idx  = last_cnt[IW-1:0];
    assign issue     = (state_reg == S_SCAN) && (rd_idx_reg < count_reg);
    // compare uses the registered read data, so it lags the read address
    assign hit_now   = pend_reg && (rd_data_reg == value_reg);
    assign scan_miss = !pend_reg && (rd_idx_reg == count_reg);
    assign mem_raddr = (state_reg == S_MOVE_RD) ? last_idx : rd_idx_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        slot_next     = slot_reg;
        hit_next      = hit_reg;
        rej_next      = rej_reg;
        mem_we        = 1'b0;
        mem_waddr     = count_reg[IW-1:0];
        mem_wdata     = value_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_command;
                    value_next  = in_value;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    rej_next    = 1'b0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN: begin
                pend_next     = issue;
                pend_idx_next = rd_idx_reg[IW-1:0];
                if (issue) begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (hit_now) begin
                    hit_next  = 1'b1;
                    slot_next = pend_idx_reg;
                    pend_next = 1'b0;
                    if (cmd_reg == CMD_REMOVE) begin
                        if (pend_idx_reg == last_idx) begin
                            // removing the last entry needs no move
                            count_next = last_cnt;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_MOVE_RD;
                        end
                    end else begin
                        state_next = S_DONE;
                    end
                end else if (scan_miss) begin
                    if (cmd_reg == CMD_INSERT) begin
                        if (count_reg < CW'(CAPACITY)) begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[IW-1:0];
                            mem_wdata  = value_reg;
                            count_next = count_reg + CW'(1);
                        end else begin
                            rej_next = 1'b1;
                        end
                    end
                    state_next = S_DONE;
                end
            end
            S_MOVE_RD: begin
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg;
                mem_wdata  = rd_data_reg;
                count_next = last_cnt;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        cmd_reg      <= cmd_next;
        value_reg    <= value_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        rej_reg      <= rej_next;
    end

    assign in_ready           = (state_reg == S_IDLE);
    assign res_valid          = (state_reg == S_DONE);
    assign res.was_present    = hit_reg;
    assign res.rejected_full  = rej_reg;
    assign res.member_count   = COUNT_OUT_W'(count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("live count above capacity");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && rej_reg |-> !hit_reg && (count_reg == CW'(CAPACITY)))
        else $error("reject without a full table");

    a_count_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) || (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("count changed outside an item");

    a_move_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE_WR) |-> hit_reg && (cmd_reg == CMD_REMOVE)
            && (slot_reg != last_idx))
        else $error("entry move without a remove hit");

endmodule

@@ test/integer_set_table_tb.sv @@
// self-checking testbench for the integer set table stream block
module integer_set_table_tb;
    import ist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP          = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 1200;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * (CAP + 5);
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        ist_cmd_e    cmd;
        logic [31:0] val;
        bit          typed_in;
        ist_result_t res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value[31:0]
    logic [0:0]  s_tuser;   // command[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // was_present[0], rejected_full[1], member_count[6:2], zero[7]

    // predictor copy of the set
    logic [31:0] set_vals [CAP];
    int          set_size;

    ist_result_t pending_results[$];
    logic [31:0] value_pool [POOL_SIZE];
    int          err_count;
    int          results_seen;
    bit          hold_active;
    bit          send_burst;
    bit          recv_burst;

    integer_set_table #(.CAPACITY(CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        err_count++;
    endtask

    // applies one command to the set copy and returns the outcome beat
    function automatic ist_result_t apply_set_op(input ist_cmd_e cmd, input logic [31:0] val);
        ist_result_t r;
        int          slot;
        slot = -1;
        for (int i = 0; i < set_size; i++) begin
            if (slot < 0 && set_vals[i] == val) slot = i;
        end
        r.was_present   = (slot >= 0);
        r.rejected_full = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (slot < 0) begin
                if (set_size < CAP) begin
                    set_vals[set_size] = val;
                    set_size++;
                end else begin
                    r.rejected_full = 1'b1;
                end
            end
        end else if (slot >= 0) begin
            // last live entry fills the hole
            set_vals[slot] = set_vals[set_size-1];
            set_size--;
        end
        r.member_count = set_size[COUNT_OUT_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t mk_row(input ist_cmd_e cmd, input logic [31:0] val,
                                        input bit typed_in, input bit present,
                                        input bit full, input int cnt);
        dir_row_t row;
        row.cmd      = cmd;
        row.val      = val;
        row.typed_in = typed_in;
        row.res      = '{member_count: cnt[COUNT_OUT_W-1:0], rejected_full: full,
                         was_present: present};
        return row;
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 6) return value_pool[$urandom_range(0, POOL_SIZE-1)];
        if (sel == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_item(input ist_cmd_e cmd, input logic [31:0] val,
                             input bit typed_in, input ist_result_t typed_res);
        ist_result_t predicted;
        int          gap;
        s_tuser  <= cmd;
        s_tdata  <= val;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predicted = apply_set_op(cmd, val);
        pending_results.push_back(typed_in ? typed_res : predicted);
        gap = (send_burst || hold_active) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // result side: random stalls, one long hold-off, field checks
    initial begin
        ist_result_t got;
        ist_result_t want;
        int          wait_cycles;
        bit          held_once;
        m_tready   = 1'b0;
        held_once  = 1'b0;
        recv_burst = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            if (!held_once && results_seen >= HOLD_AFTER) begin
                held_once   = 1'b1;
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end else begin
                wait_cycles = recv_burst ? 0 : $urandom_range(0, 16);
                if (wait_cycles > 0) begin
                    m_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
            got = ist_result_t'(m_tdata[6:0]);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat 0x%02h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.was_present !== want.was_present)
                    report_mismatch($sformatf("beat %0d was_present %b, want %b",
                                              results_seen, got.was_present,
                                              want.was_present));
                if (got.rejected_full !== want.rejected_full)
                    report_mismatch($sformatf("beat %0d rejected_full %b, want %b",
                                              results_seen, got.rejected_full,
                                              want.rejected_full));
                if (got.member_count !== want.member_count)
                    report_mismatch($sformatf("beat %0d member_count %0d, want %0d",
                                              results_seen, got.member_count,
                                              want.member_count));
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        dir_row_t    dir_rows[$];
        ist_cmd_e    cmd;
        int          insert_pct;
        int          phase_left;
        ist_result_t unused_res;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= CMD_INSERT;
        err_count    = 0;
        results_seen = 0;
        hold_active  = 1'b0;
        send_burst   = 1'b0;
        set_size     = 0;
        unused_res   = '0;
        for (int i = 0; i < CAP; i++) set_vals[i] = '0;
        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom;

        // directed: empty table, extremes, duplicates, absent remove, fill, full reject
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'd5,        1, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h8000_0000, 1, 0, 0, 1));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h7fff_ffff, 1, 0, 0, 2));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h8000_0000, 1, 1, 0, 2));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'h0000_0000, 1, 0, 0, 2));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'h8000_0000, 1, 1, 0, 1));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'hffff_ffff, 0, 0, 0, 0));
        for (int i = 1; i <= CAP - 2; i++)
            dir_rows.push_back(mk_row(CMD_INSERT, 32'(i), 0, 0, 0, 0));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h1234_5678, 1, 0, 1, CAP));
        dir_rows.push_back(mk_row(CMD_INSERT, 32'h7fff_ffff, 1, 1, 0, CAP));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'h7fff_ffff, 1, 1, 0, CAP - 1));
        dir_rows.push_back(mk_row(CMD_REMOVE, 32'hffff_ffff, 1, 1, 0, CAP - 2));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].typed_in, dir_rows[i].res);

        // random: phases that lean toward filling or draining the table
        insert_pct = 75;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                insert_pct = (insert_pct > 50) ? 30 : 75;
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_item(cmd, pick_value(), 0, unused_res);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
